### hdl/dss_pkg.sv
// Package for the disk sector store: opcodes, reset geometry and fixed reply bytes.
// Used by disk_sector_store; no dependencies.
package dss_pkg;

  localparam int unsigned IMAGE_BYTES_DEF = 262144;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_SIZE      = 3'd2;
  localparam logic [2:0] OP_STATUS    = 3'd3;
  localparam logic [2:0] OP_RD_CFG    = 3'd4;
  localparam logic [2:0] OP_WR_CFG    = 3'd5;
  localparam logic [2:0] OP_FMT_AUTO  = 3'd6;
  localparam logic [2:0] OP_FMT_MED   = 3'd7;

  localparam logic [15:0] SSIZE_SD    = 16'h0080;
  localparam logic [15:0] SSIZE_DD    = 16'h0100;
  localparam logic [15:0] SPT_SD      = 16'd18;
  localparam logic [15:0] SPT_MED     = 16'd26;
  localparam logic [7:0]  TRACKS_STD  = 8'd40;
  localparam logic [7:0]  SIDES_STD   = 8'd1;
  localparam logic [7:0]  MODE_FM     = 8'd0;
  localparam logic [7:0]  MODE_MFM    = 8'd4;
  localparam logic [31:0] IMG_SD      = 32'd92160;
  localparam logic [15:0] HDR_ISZ_RST = 16'd5760;
  localparam logic [8:0]  BOOT_BYTES  = 9'd384;

  localparam logic [7:0] STAT_BAD_SPT = 8'h80;
  localparam logic [7:0] STAT_DD      = 8'h20;
  localparam logic [7:0] STAT_B1      = 8'h20;
  localparam logic [7:0] STAT_B2      = 8'he0;
  localparam logic [7:0] STAT_B3      = 8'h10;
  localparam logic [7:0] CFG_PRESENT  = 8'hff;

  localparam logic [3:0] STAT_LAST_BEAT = 4'd3;
  localparam logic [3:0] CFG_LAST_BEAT  = 4'd11;

endpackage

### hdl/dss_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependency.
module dss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/disk_sector_store.sv
// Top level of the disk sector store: command sequencer, geometry registers, image RAM.
// Depends on dss_pkg and dss_ram.
//
// Usage: one command beat enters on in_* (valid/ready). Each command gives one
// result beat on out_*, except status (4 beats) and read config (12 beats);
// out_last marks the final beat of a command.
// Path: a byte read goes through MUL, EXEC and RDWAIT to the output register in EMIT;
// a byte write, size query or refused config through MUL and EXEC; an accepted config
// write adds GEO1 and GEO2. Commands are handled one at a time; in_ready rises as the
// last beat enters the output register.
// Format walks the image RAM through its single write port, one byte a cycle,
// clearing min(image size, IMAGE_BYTES) bytes.
// Reset: geometry returns to single density (128-byte sectors, 18 per track,
// 40 tracks, one side) and the whole RAM is cleared, which holds in_ready low
// while the clear runs after reset.
// Stall: the result sits in an output register; while out_ready is low the
// sequencer waits with the next beat; once the last beat is registered it takes a new command.
module disk_sector_store #(
  parameter int unsigned IMAGE_BYTES = dss_pkg::IMAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [11:0] in_sector,
  input  logic [7:0]  in_byte_index,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_new_tracks,
  input  logic [15:0] in_new_sectors_per_track,
  input  logic [7:0]  in_new_sides_minus_one,
  input  logic [7:0]  in_new_mode,
  input  logic [15:0] in_new_sector_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data,
  output logic [15:0] out_size,
  output logic        out_error,
  output logic        out_last
);

  localparam int unsigned AW = $clog2(IMAGE_BYTES);
  localparam int unsigned CW = $clog2(IMAGE_BYTES + 1);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_EXEC   = 4'd3;
  localparam logic [3:0] ST_RDWAIT = 4'd4;
  localparam logic [3:0] ST_GEO1   = 4'd5;
  localparam logic [3:0] ST_GEO2   = 4'd6;
  localparam logic [3:0] ST_FMT    = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  // Control and geometry state.
  logic [3:0]  state_r, state_nxt;
  logic [3:0]  beat_r, beat_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0] clr_lim_r, clr_lim_nxt;
  logic [15:0] sb_r, sb_nxt;
  logic [15:0] spt_r, spt_nxt;
  logic [7:0]  trk_r, trk_nxt;
  logic [7:0]  sides_r, sides_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [31:0] img_r, img_nxt;
  logic [15:0] hdr_isz_r, hdr_isz_nxt;
  logic [15:0] hdr_ssz_r, hdr_ssz_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [2:0]  op_r, op_nxt;
  logic [11:0] sec_r, sec_nxt;
  logic [7:0]  bi_r, bi_nxt;
  logic [7:0]  wd_r, wd_nxt;
  logic [7:0]  ntrk_r, ntrk_nxt;
  logic [15:0] nspt_r, nspt_nxt;
  logic [7:0]  nsides_r, nsides_nxt;
  logic [7:0]  nmode_r, nmode_nxt;
  logic [15:0] nsb_r, nsb_nxt;
  logic [31:0] mul_r, mul_nxt;
  logic [7:0]  res_data_r, res_data_nxt;
  logic [15:0] res_size_r, res_size_nxt;
  logic        res_err_r, res_err_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [15:0] out_size_r, out_size_nxt;
  logic        out_error_r, out_error_nxt;
  logic        out_last_r, out_last_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic        in_acc, out_free;
  logic [11:0] sec_n;
  logic [15:0] acc_size;
  logic [28:0] acc_off, acc_addr;
  logic [19:0] fb_sz;
  logic [37:0] geo_v;
  logic [31:0] geo_img;
  logic [3:0]  last_beat;
  logic [7:0]  beat_data;

  dss_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sector address arithmetic; boot sectors are fixed at 128 bytes.
  assign sec_n    = sec_r - 12'd1;
  assign acc_size = (sec_n > 12'd2) ? sb_r : dss_pkg::SSIZE_SD;
  assign acc_off  = (sec_n >= 12'd3) ? (29'(dss_pkg::BOOT_BYTES) + mul_r[28:0])
                                     : {20'd0, sec_n[1:0], 7'd0};
  assign acc_addr = acc_off + 29'(bi_r);
  assign fb_sz    = {hdr_isz_r, 4'd0};
  // Image size = sector size * spt * 40 (one side), less the boot area when not 128.
  assign geo_v    = ({6'd0, mul_r} << 5) + ({6'd0, mul_r} << 3);
  assign geo_img  = geo_v[31:0] -
                    ((sb_r != dss_pkg::SSIZE_SD) ? 32'(dss_pkg::BOOT_BYTES) : 32'd0);

  always_comb begin
    case (op_r)
      dss_pkg::OP_STATUS: last_beat = dss_pkg::STAT_LAST_BEAT;
      dss_pkg::OP_RD_CFG: last_beat = dss_pkg::CFG_LAST_BEAT;
      default:            last_beat = 4'd0;
    endcase
  end

  always_comb begin
    beat_data = res_data_r;
    if (op_r == dss_pkg::OP_STATUS) begin
      case (beat_r)
        4'd0: begin
          if (spt_r == dss_pkg::SPT_SD) begin
            beat_data = (sb_r == dss_pkg::SSIZE_DD) ? dss_pkg::STAT_DD : 8'h00;
          end else begin
            beat_data = dss_pkg::STAT_BAD_SPT;
          end
        end
        4'd1:    beat_data = dss_pkg::STAT_B1;
        4'd2:    beat_data = dss_pkg::STAT_B2;
        default: beat_data = dss_pkg::STAT_B3;
      endcase
    end else if (op_r == dss_pkg::OP_RD_CFG) begin
      case (beat_r)
        4'd0:    beat_data = trk_r;
        4'd2:    beat_data = spt_r[15:8];
        4'd3:    beat_data = spt_r[7:0];
        4'd4:    beat_data = sides_r - 8'd1;
        4'd5:    beat_data = mode_r;
        4'd6:    beat_data = sb_r[15:8];
        4'd7:    beat_data = sb_r[7:0];
        4'd8:    beat_data = dss_pkg::CFG_PRESENT;
        default: beat_data = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    beat_nxt      = beat_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_lim_nxt   = clr_lim_r;
    sb_nxt        = sb_r;
    spt_nxt       = spt_r;
    trk_nxt       = trk_r;
    sides_nxt     = sides_r;
    mode_nxt      = mode_r;
    img_nxt       = img_r;
    hdr_isz_nxt   = hdr_isz_r;
    hdr_ssz_nxt   = hdr_ssz_r;
    op_nxt        = op_r;
    sec_nxt       = sec_r;
    bi_nxt        = bi_r;
    wd_nxt        = wd_r;
    ntrk_nxt      = ntrk_r;
    nspt_nxt      = nspt_r;
    nsides_nxt    = nsides_r;
    nmode_nxt     = nmode_r;
    nsb_nxt       = nsb_r;
    mul_nxt       = mul_r;
    res_data_nxt  = res_data_r;
    res_size_nxt  = res_size_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_size_nxt  = out_size_r;
    out_error_nxt = out_error_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = clr_cnt_r[AW-1:0];
    ram_wdata     = 8'h00;
    ram_raddr     = acc_addr[AW-1:0];

    case (state_r)
      ST_INIT, ST_FMT: begin
        if (clr_cnt_r == clr_lim_r) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_EMIT;
        end else begin
          ram_we      = 1'b1;
          clr_cnt_nxt = clr_cnt_r + CW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_opcode;
          sec_nxt      = in_sector;
          bi_nxt       = in_byte_index;
          wd_nxt       = in_write_data;
          ntrk_nxt     = in_new_tracks;
          nspt_nxt     = in_new_sectors_per_track;
          nsides_nxt   = in_new_sides_minus_one;
          nmode_nxt    = in_new_mode;
          nsb_nxt      = in_new_sector_size;
          res_data_nxt = 8'h00;
          res_size_nxt = 16'd0;
          res_err_nxt  = 1'b0;
          beat_nxt     = 4'd0;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_nxt   = 32'(sec_n - 12'd3) * 32'(sb_r);
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_EMIT;
        case (op_r)
          dss_pkg::OP_READ, dss_pkg::OP_WRITE, dss_pkg::OP_SIZE: begin
            if (sec_r == 12'd0) begin
              res_err_nxt = 1'b1;
            end else begin
              res_size_nxt = acc_size;
              if (op_r != dss_pkg::OP_SIZE) begin
                if ((16'(bi_r) >= acc_size) || (acc_addr >= 29'(IMAGE_BYTES))) begin
                  res_err_nxt = 1'b1;
                end else if (op_r == dss_pkg::OP_READ) begin
                  ram_re    = 1'b1;
                  state_nxt = ST_RDWAIT;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = acc_addr[AW-1:0];
                  ram_wdata = wd_r;
                end
              end
            end
          end
          dss_pkg::OP_WR_CFG: begin
            trk_nxt   = ntrk_r;
            spt_nxt   = nspt_r;
            sides_nxt = nsides_r + 8'd1;
            mode_nxt  = nmode_r;
            sb_nxt    = nsb_r;
            if ((ntrk_r != dss_pkg::TRACKS_STD) || (nsides_r != 8'd0)) begin
              // Refused block: rebuild the geometry from the stored header.
              res_err_nxt = 1'b1;
              img_nxt     = 32'(fb_sz);
              if (32'(fb_sz) <= 32'(IMAGE_BYTES)) begin
                sb_nxt = hdr_ssz_r;
                if ((hdr_ssz_r == dss_pkg::SSIZE_SD) || (hdr_ssz_r == dss_pkg::SSIZE_DD)) begin
                  trk_nxt   = dss_pkg::TRACKS_STD;
                  spt_nxt   = dss_pkg::SPT_SD;
                  sides_nxt = dss_pkg::SIDES_STD;
                  mode_nxt  = dss_pkg::MODE_MFM;
                  if (hdr_ssz_r == dss_pkg::SSIZE_SD) begin
                    mode_nxt = dss_pkg::MODE_FM;
                    if (32'(fb_sz) > dss_pkg::IMG_SD) begin
                      spt_nxt  = dss_pkg::SPT_MED;
                      mode_nxt = dss_pkg::MODE_MFM;
                    end
                  end
                end
              end
            end else begin
              state_nxt = ST_GEO1;
            end
          end
          dss_pkg::OP_FMT_AUTO: begin
            res_size_nxt = sb_r;
            clr_cnt_nxt  = '0;
            clr_lim_nxt  = (img_r > 32'(IMAGE_BYTES)) ? CW'(IMAGE_BYTES) : img_r[CW-1:0];
            state_nxt    = ST_FMT;
          end
          dss_pkg::OP_FMT_MED: begin
            trk_nxt   = dss_pkg::TRACKS_STD;
            spt_nxt   = dss_pkg::SPT_MED;
            sides_nxt = dss_pkg::SIDES_STD;
            mode_nxt  = dss_pkg::MODE_MFM;
            sb_nxt    = dss_pkg::SSIZE_SD;
            state_nxt = ST_GEO1;
          end
          default: ;
        endcase
      end
      ST_RDWAIT: begin
        res_data_nxt = ram_rdata;
        state_nxt    = ST_EMIT;
      end
      ST_GEO1: begin
        mul_nxt   = sb_r * spt_r;
        state_nxt = ST_GEO2;
      end
      ST_GEO2: begin
        img_nxt     = geo_img;
        hdr_isz_nxt = geo_img[19:4];
        hdr_ssz_nxt = sb_r;
        if (op_r == dss_pkg::OP_FMT_MED) begin
          res_size_nxt = dss_pkg::SSIZE_SD;
          clr_cnt_nxt  = '0;
          clr_lim_nxt  = (geo_img > 32'(IMAGE_BYTES)) ? CW'(IMAGE_BYTES) : geo_img[CW-1:0];
          state_nxt    = ST_FMT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = beat_data;
          out_size_nxt  = res_size_r;
          out_error_nxt = res_err_r;
          out_last_nxt  = (beat_r == last_beat);
          if (beat_r == last_beat) begin
            state_nxt = ST_IDLE;
          end else begin
            beat_nxt = beat_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      beat_r      <= 4'd0;
      clr_cnt_r   <= '0;
      clr_lim_r   <= CW'(IMAGE_BYTES);
      sb_r        <= dss_pkg::SSIZE_SD;
      spt_r       <= dss_pkg::SPT_SD;
      trk_r       <= dss_pkg::TRACKS_STD;
      sides_r     <= dss_pkg::SIDES_STD;
      mode_r      <= dss_pkg::MODE_FM;
      img_r       <= dss_pkg::IMG_SD;
      hdr_isz_r   <= dss_pkg::HDR_ISZ_RST;
      hdr_ssz_r   <= dss_pkg::SSIZE_SD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      beat_r      <= beat_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_lim_r   <= clr_lim_nxt;
      sb_r        <= sb_nxt;
      spt_r       <= spt_nxt;
      trk_r       <= trk_nxt;
      sides_r     <= sides_nxt;
      mode_r      <= mode_nxt;
      img_r       <= img_nxt;
      hdr_isz_r   <= hdr_isz_nxt;
      hdr_ssz_r   <= hdr_ssz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    sec_r       <= sec_nxt;
    bi_r        <= bi_nxt;
    wd_r        <= wd_nxt;
    ntrk_r      <= ntrk_nxt;
    nspt_r      <= nspt_nxt;
    nsides_r    <= nsides_nxt;
    nmode_r     <= nmode_nxt;
    nsb_r       <= nsb_nxt;
    mul_r       <= mul_nxt;
    res_data_r  <= res_data_nxt;
    res_size_r  <= res_size_nxt;
    res_err_r   <= res_err_nxt;
    out_data_r  <= out_data_nxt;
    out_size_r  <= out_size_nxt;
    out_error_r <= out_error_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_size  = out_size_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

  // The image is being cleared right after reset, so no command may enter.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command accepted during post-reset clear");

  // Writes to the image only come from a command or a clearing sweep.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("image write while idle");

  // An accepted command always starts the offset multiply.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL))
    else $error("sequencer did not start after accept");

endmodule
